[rtl/record_table_with_owner_locks_defines.svh]
// Assertion macros for the record table checker.
// Each macro expects signals named clock and reset in the using scope.
`ifndef RECORD_TABLE_WITH_OWNER_LOCKS_DEFINES_SVH
`define RECORD_TABLE_WITH_OWNER_LOCKS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTOL_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTOL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rtol_pkg.sv]
// Shared types and constants for the record table with owner locks.
// No dependencies; every other file but the assertion macros header imports this package.
`default_nettype none

package rtol_pkg;

   // request and response field widths
   localparam int OP_W      = 3;
   localparam int REQ_W     = 16;
   localparam int IDX_W     = 10;
   localparam int DIN_W     = 64;
   localparam int STATUS_W  = 4;
   localparam int OWN_IO_W  = 16;

   // parameter defaults
   localparam int CAPACITY_DEF        = 1024;
   localparam int INITIAL_RECORDS_DEF = 1000;
   localparam int DATA_WIDTH_DEF      = 64;
   localparam int OWNER_WIDTH_DEF     = 16;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND   = 3'd0,
      OP_WRITE    = 3'd1,
      OP_READ     = 3'd2,
      OP_DELETE   = 3'd3,
      OP_UNDELETE = 3'd4,
      OP_LOCK     = 3'd5,
      OP_UNLOCK   = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK             = 4'd0,
      ST_BAD_INDEX      = 4'd1,
      ST_LOCKED_OTHER   = 4'd2,
      ST_EMPTY          = 4'd3,
      ST_DELETED        = 4'd4,
      ST_OCCUPIED       = 4'd5,
      ST_ALREADY_LOCKED = 4'd6,
      ST_NOT_LOCKED     = 4'd7,
      ST_FULL           = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      REC_EMPTY    = 2'd0,
      REC_OCCUPIED = 2'd1,
      REC_DELETED  = 2'd2
   } rec_state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_en;
      logic accept_en;
      logic commit_en;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic rsp_busy;
   } dp_stat_type;

endpackage

`default_nettype wire

[rtl/rtol_if.sv]
// Request and response channel interfaces (valid/ready plus payload).
// Depends on rtol_pkg for field widths.
`default_nettype none

interface rtol_req_if import rtol_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [REQ_W-1:0]    requester;
   logic [IDX_W-1:0]    index;
   logic [DIN_W-1:0]    data_in;

   modport source (output valid, operation, requester, index, data_in, input ready);
   modport sink   (input valid, operation, requester, index, data_in, output ready);
endinterface

interface rtol_rsp_if import rtol_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    index_out;
   logic [DIN_W-1:0]    data_out;
   logic [OWN_IO_W-1:0] owner_out;

   modport source (output valid, status, index_out, data_out, owner_out, input ready);
   modport sink   (input valid, status, index_out, data_out, owner_out, output ready);
endinterface

`default_nettype wire

[rtl/rtol_ctrl.sv]
// Controller state machine: clearing pass, request intake, commit.
// Depends on rtol_pkg for the command and status structs.
`default_nettype none

module rtol_ctrl import rtol_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept_en = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            // wait for the response slot, then write back and respond
            if (!stat.rsp_busy) begin
               cmd.commit_en = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

[rtl/rtol_dpath.sv]
// Datapath: record memories, request registers, decision logic, response register.
// Depends on rtol_pkg; driven by rtol_ctrl commands.
`default_nettype none

module rtol_dpath import rtol_pkg::*; #(
   parameter int CAPACITY        = CAPACITY_DEF,
   parameter int INITIAL_RECORDS = INITIAL_RECORDS_DEF,
   parameter int DATA_WIDTH      = DATA_WIDTH_DEF,
   parameter int OWNER_WIDTH     = OWNER_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_stat_type         stat,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [REQ_W-1:0]    req_requester,
   input  logic [IDX_W-1:0]    req_index,
   input  logic [DIN_W-1:0]    req_data_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]    rsp_index_out,
   output logic [DIN_W-1:0]    rsp_data_out,
   output logic [OWN_IO_W-1:0] rsp_owner_out
);

   localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW       = $clog2(CAPACITY + 1);
   localparam int CMPW     = (CW > IDX_W) ? CW : IDX_W;
   localparam int META_W   = OWNER_WIDTH + 2;
   localparam int INIT_EFF = (INITIAL_RECORDS > CAPACITY) ? CAPACITY : INITIAL_RECORDS;

   // meta word is {owner, state}
   logic [META_W-1:0]     meta_mem [CAPACITY];
   logic [DATA_WIDTH-1:0] data_mem [CAPACITY];

   logic [OP_W-1:0]        op_ff;
   logic [OWNER_WIDTH-1:0] req_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [DATA_WIDTH-1:0]  din_ff;
   logic [META_W-1:0]      rd_meta_ff;
   logic [DATA_WIDTH-1:0]  rd_data_ff;

   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          clear_cnt_ff, clear_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff;
   logic [IDX_W-1:0]       idx_out_ff;
   logic [DIN_W-1:0]       dout_ff;
   logic [OWN_IO_W-1:0]    own_out_ff;

   logic [1:0]             rec_st;
   logic [OWNER_WIDTH-1:0] own;
   logic                   bad_c;
   logic                   full_c;
   logic                   locked_other_c;
   status_type             not_occ_c;
   status_type             status_c;
   logic [IDX_W-1:0]       idx_out_c;
   logic [DATA_WIDTH-1:0]  dout_c;
   logic [OWNER_WIDTH-1:0] own_out_c;
   logic                   meta_wr_c;
   logic                   data_wr_c;
   logic                   append_c;
   logic [META_W-1:0]      meta_wdata_c;
   logic [AW-1:0]          wr_addr;
   logic                   meta_we;
   logic [META_W-1:0]      meta_wd;
   logic                   data_we;

   assign rec_st         = rd_meta_ff[1:0];
   assign own            = rd_meta_ff[META_W-1:2];
   assign bad_c          = CMPW'(idx_ff) >= CMPW'(count_ff);
   assign full_c         = count_ff == CW'(CAPACITY);
   assign locked_other_c = (own != '0) && (own != req_ff);
   assign not_occ_c      = (rec_st == REC_EMPTY) ? ST_EMPTY : ST_DELETED;

   always_comb begin
      status_c     = ST_OK;
      idx_out_c    = idx_ff;
      dout_c       = '0;
      own_out_c    = '0;
      meta_wr_c    = 1'b0;
      data_wr_c    = 1'b0;
      append_c     = 1'b0;
      meta_wdata_c = rd_meta_ff;
      priority if (op_ff == OP_APPEND) begin
         if (full_c) begin
            status_c  = ST_FULL;
            idx_out_c = '0;
         end else begin
            idx_out_c    = IDX_W'(count_ff);
            meta_wr_c    = 1'b1;
            data_wr_c    = 1'b1;
            append_c     = 1'b1;
            meta_wdata_c = {{OWNER_WIDTH{1'b0}}, REC_OCCUPIED};
            dout_c       = din_ff;
         end
      end else if ((op_ff > OP_UNLOCK) || bad_c) begin
         status_c = ST_BAD_INDEX;
      end else begin
         unique case (op_ff)
            OP_LOCK: begin
               priority if (own != '0) begin
                  status_c  = ST_ALREADY_LOCKED;
                  own_out_c = own;
               end else if (rec_st != REC_OCCUPIED) begin
                  status_c = not_occ_c;
               end else begin
                  meta_wr_c    = 1'b1;
                  meta_wdata_c = {req_ff, rec_st};
                  dout_c       = rd_data_ff;
               end
            end
            OP_UNLOCK: begin
               priority if (own == '0) begin
                  status_c = ST_NOT_LOCKED;
               end else if (own != req_ff) begin
                  status_c  = ST_LOCKED_OTHER;
                  own_out_c = own;
               end else if (rec_st != REC_OCCUPIED) begin
                  status_c = not_occ_c;
               end else begin
                  meta_wr_c    = 1'b1;
                  meta_wdata_c = {{OWNER_WIDTH{1'b0}}, rec_st};
                  dout_c       = rd_data_ff;
               end
            end
            OP_WRITE: begin
               if (locked_other_c) begin
                  status_c  = ST_LOCKED_OTHER;
                  own_out_c = own;
               end else begin
                  meta_wr_c    = 1'b1;
                  data_wr_c    = 1'b1;
                  meta_wdata_c = {own, REC_OCCUPIED};
                  dout_c       = din_ff;
               end
            end
            OP_READ: begin
               priority if (locked_other_c) begin
                  status_c  = ST_LOCKED_OTHER;
                  own_out_c = own;
               end else if (rec_st != REC_OCCUPIED) begin
                  status_c = not_occ_c;
               end else begin
                  dout_c = rd_data_ff;
               end
            end
            OP_DELETE: begin
               priority if (locked_other_c) begin
                  status_c  = ST_LOCKED_OTHER;
                  own_out_c = own;
               end else if (rec_st != REC_OCCUPIED) begin
                  status_c = not_occ_c;
               end else begin
                  meta_wr_c    = 1'b1;
                  meta_wdata_c = {own, REC_DELETED};
               end
            end
            OP_UNDELETE: begin
               priority if (locked_other_c) begin
                  status_c  = ST_LOCKED_OTHER;
                  own_out_c = own;
               end else if (rec_st == REC_EMPTY) begin
                  status_c = ST_EMPTY;
               end else if (rec_st == REC_OCCUPIED) begin
                  status_c = ST_OCCUPIED;
               end else begin
                  meta_wr_c    = 1'b1;
                  meta_wdata_c = {own, REC_OCCUPIED};
                  dout_c       = rd_data_ff;
               end
            end
            default: status_c = ST_BAD_INDEX;
         endcase
      end
   end

   // one write port shared by the clearing pass and the commit
   assign wr_addr = cmd.clear_en ? clear_cnt_ff :
                    (append_c ? AW'(count_ff) : AW'(idx_ff));
   assign meta_we = cmd.clear_en | (cmd.commit_en & meta_wr_c);
   assign meta_wd = cmd.clear_en ? '0 : meta_wdata_c;
   assign data_we = cmd.commit_en & data_wr_c;

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[wr_addr] <= meta_wd;
      if (data_we) data_mem[wr_addr] <= din_ff;
      if (cmd.accept_en) begin
         rd_meta_ff <= meta_mem[AW'(req_index)];
         rd_data_ff <= data_mem[AW'(req_index)];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.accept_en) begin
         op_ff  <= req_operation;
         req_ff <= OWNER_WIDTH'(req_requester);
         idx_ff <= req_index;
         din_ff <= DATA_WIDTH'(req_data_in);
      end
   end

   // response capture
   always_ff @(posedge clock) begin
      if (cmd.commit_en) begin
         status_ff  <= status_c;
         idx_out_ff <= idx_out_c;
         dout_ff    <= DIN_W'(dout_c);
         own_out_ff <= OWN_IO_W'(own_out_c);
      end
   end

   assign count_in     = (cmd.commit_en && append_c) ? count_ff + CW'(1) : count_ff;
   assign clear_cnt_in = cmd.clear_en ? clear_cnt_ff + AW'(1) : clear_cnt_ff;
   assign rsp_valid_in = cmd.commit_en ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CW'(INIT_EFF);
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.clear_last = clear_cnt_ff == AW'(CAPACITY - 1);
   assign stat.rsp_busy   = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_index_out = idx_out_ff;
   assign rsp_data_out  = dout_ff;
   assign rsp_owner_out = own_out_ff;

endmodule

`default_nettype wire

[rtl/record_table_with_owner_locks.sv]
// Record table with per-record owner locks. Each request carries an operation
// (append, write, read, delete, undelete, lock, unlock), a requester id, a record
// index and a data word, and produces exactly one response with a status code,
// the index, a data word and a lock owner. A request is taken when the block is
// idle; the record memories are read synchronously at the accepting edge, and in
// the execute state the decision is made, the record is written back and the
// response register is loaded. The response is therefore valid from the edge
// that ends the execute state, and the block takes a new request only after the
// previous one has been written back; the read-modify-write on the record
// memories sets that limit. A stalled response holds the next request in its
// decision cycle until the response register frees up, and the response
// register lets a new request enter while the previous response still waits.
// After reset the block runs a clearing pass over all CAPACITY record entries,
// one entry per cycle, with ready held low.
// Depends on rtol_pkg, rtol_if, rtol_ctrl and rtol_dpath.
`default_nettype none

module record_table_with_owner_locks import rtol_pkg::*; #(
   parameter int CAPACITY        = CAPACITY_DEF,
   parameter int INITIAL_RECORDS = INITIAL_RECORDS_DEF,
   parameter int DATA_WIDTH      = DATA_WIDTH_DEF,
   parameter int OWNER_WIDTH     = OWNER_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rtol_req_if.sink   req_if,
   rtol_rsp_if.source rsp_if
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // sequence clear, intake and commit
   rtol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold the records and build each response
   rtol_dpath #(
      .CAPACITY        (CAPACITY),
      .INITIAL_RECORDS (INITIAL_RECORDS),
      .DATA_WIDTH      (DATA_WIDTH),
      .OWNER_WIDTH     (OWNER_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_operation (req_if.operation),
      .req_requester (req_if.requester),
      .req_index     (req_if.index),
      .req_data_in   (req_if.data_in),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_status    (rsp_if.status),
      .rsp_index_out (rsp_if.index_out),
      .rsp_data_out  (rsp_if.data_out),
      .rsp_owner_out (rsp_if.owner_out)
   );

endmodule

`default_nettype wire

[rtl/rtol_checker.sv]
// Port-level checks for the record table, bound to the top level.
// Depends on rtol_pkg and the assertion macros header.
`default_nettype none
`include "record_table_with_owner_locks_defines.svh"

module rtol_checker import rtol_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [IDX_W-1:0]    rsp_index_out,
   input logic [DIN_W-1:0]    rsp_data_out,
   input logic [OWN_IO_W-1:0] rsp_owner_out
);

   // a stalled response holds
   `RTOL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_index_out) && $stable(rsp_data_out) && $stable(rsp_owner_out), "stalled response changed")

   // one request in flight at a time
   `RTOL_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")

   // an owner is reported only on lock conflicts
   `RTOL_ASSERT_SAME(a_owner_on_conflict, rsp_valid && (rsp_owner_out != '0), (rsp_status == ST_LOCKED_OTHER) || (rsp_status == ST_ALREADY_LOCKED), "owner reported without lock conflict")

   // failed requests return no data
   `RTOL_ASSERT_SAME(a_no_data_on_error, rsp_valid && (rsp_status != ST_OK), rsp_data_out == '0, "data returned on error status")

endmodule

bind record_table_with_owner_locks rtol_checker u_rtol_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_status    (rsp_if.status),
   .rsp_index_out (rsp_if.index_out),
   .rsp_data_out  (rsp_if.data_out),
   .rsp_owner_out (rsp_if.owner_out)
);

`default_nettype wire

[tb/record_table_with_owner_locks_tb.sv]
// Self-checking bench for record_table_with_owner_locks: directed opening requests,
// then random lock sessions and loose requests, checked against an in-bench table model.
// Depends on rtol_pkg and the rtol_req_if / rtol_rsp_if interfaces of the RTL.
module record_table_with_owner_locks_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rtol_pkg::*;

   localparam int CAPACITY        = CAPACITY_DEF;
   localparam int START_RECORDS   = INITIAL_RECORDS_DEF;
   localparam int RANDOM_REQUESTS = 1150;
   // the one opcode the field can carry that the package leaves unnamed
   localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;

   typedef struct {
      logic [OP_W-1:0]  operation;
      logic [REQ_W-1:0] requester;
      logic [IDX_W-1:0] index;
      logic [DIN_W-1:0] data_in;
      int               gap;    // idle cycles ahead of this request
      bit               drain;  // hold this request until every reply is back
   } table_request;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    index_out;
      logic [DIN_W-1:0]    data_out;
      logic [OWN_IO_W-1:0] owner_out;
   } table_reply;

   logic clock = 1'b0;
   logic reset;

   rtol_req_if req_if ();
   rtol_rsp_if rsp_if ();

   record_table_with_owner_locks #(
      .CAPACITY        (CAPACITY),
      .INITIAL_RECORDS (START_RECORDS),
      .DATA_WIDTH      (DATA_WIDTH_DEF),
      .OWNER_WIDTH     (OWNER_WIDTH_DEF)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Table model: the bench's own copy of every record.
   // ------------------------------------------------------------------
   rec_state_type    row_state [CAPACITY];
   logic [DIN_W-1:0] row_data  [CAPACITY];
   logic [REQ_W-1:0] row_owner [CAPACITY];
   int               live_records;

   table_request request_queue[$];     // requests waiting for the driver
   table_reply   awaited_replies[$];   // replies owed by the block, oldest first

   int  queued_requests = 0;
   int  requests_taken  = 0;
   int  replies_checked = 0;
   int  mismatch_count  = 0;
   int  status_seen [9];
   logic req_fire;

   // Status for a record that is not occupied.
   function automatic status_type absent_status(rec_state_type st);
      return (st == REC_EMPTY) ? ST_EMPTY : ST_DELETED;
   endfunction

   // Apply one request to the table model and return the reply it earns.
   function automatic table_reply apply_table_op(logic [OP_W-1:0] op, logic [REQ_W-1:0] who,
                                                 logic [IDX_W-1:0] slot,
                                                 logic [DIN_W-1:0] word);
      table_reply       reply;
      rec_state_type    cur_state;
      logic [REQ_W-1:0] cur_owner;
      reply.status    = ST_OK;
      reply.index_out = slot;
      reply.data_out  = '0;
      reply.owner_out = '0;
      cur_state = row_state[slot];
      cur_owner = row_owner[slot];
      if (op == OP_APPEND) begin
         if (live_records >= CAPACITY) begin
            reply.status    = ST_FULL;
            reply.index_out = '0;
         end else begin
            reply.index_out         = IDX_W'(live_records);
            row_state[live_records] = REC_OCCUPIED;
            row_data[live_records]  = word;
            row_owner[live_records] = '0;
            live_records++;
            reply.data_out = word;
         end
      end else if (op == OP_UNDEFINED || int'(slot) >= live_records) begin
         reply.status = ST_BAD_INDEX;
      end else if (op == OP_LOCK) begin
         if (cur_owner != '0) begin
            // relocking is refused even for the holder
            reply.status    = ST_ALREADY_LOCKED;
            reply.owner_out = cur_owner;
         end else if (cur_state != REC_OCCUPIED) begin
            reply.status = absent_status(cur_state);
         end else begin
            row_owner[slot] = who;   // requester zero leaves it unlocked
            reply.data_out  = row_data[slot];
         end
      end else if (op == OP_UNLOCK) begin
         if (cur_owner == '0) begin
            reply.status = ST_NOT_LOCKED;
         end else if (cur_owner != who) begin
            reply.status    = ST_LOCKED_OTHER;
            reply.owner_out = cur_owner;
         end else if (cur_state != REC_OCCUPIED) begin
            reply.status = absent_status(cur_state);
         end else begin
            row_owner[slot] = '0;
            reply.data_out  = row_data[slot];
         end
      end else if (cur_owner != '0 && cur_owner != who) begin
         reply.status    = ST_LOCKED_OTHER;
         reply.owner_out = cur_owner;
      end else if (op == OP_WRITE) begin
         row_state[slot] = REC_OCCUPIED;
         row_data[slot]  = word;
         reply.data_out  = word;
      end else if (op == OP_READ) begin
         if (cur_state != REC_OCCUPIED) reply.status = absent_status(cur_state);
         else reply.data_out = row_data[slot];
      end else if (op == OP_DELETE) begin
         if (cur_state != REC_OCCUPIED) reply.status = absent_status(cur_state);
         else row_state[slot] = REC_DELETED;
      end else begin
         // undelete
         if (cur_state == REC_EMPTY) begin
            reply.status = ST_EMPTY;
         end else if (cur_state == REC_OCCUPIED) begin
            reply.status = ST_OCCUPIED;
         end else begin
            row_state[slot] = REC_OCCUPIED;
            reply.data_out  = row_data[slot];
         end
      end
      return reply;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Idle stretch: picked from three bands, the shortest band most often, the longest rarely.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 2);
      else if (pick < 95) return $urandom_range(3, 8);
      else return $urandom_range(20, 50);
   endfunction

   // Favor a few hot records and the live boundary so that state and locks interact.
   function automatic logic [IDX_W-1:0] pick_slot();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return IDX_W'($urandom_range(0, 7));
      else if (pick < 80) return IDX_W'($urandom_range(995, 1023));
      else return IDX_W'($urandom_range(0, 1023));
   endfunction

   function automatic logic [REQ_W-1:0] pick_client();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return REQ_W'($urandom_range(1, 4));
      else if (pick < 75) return '0;
      else if (pick < 85) return '1;
      else return REQ_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [DIN_W-1:0] pick_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return '1;
      else if (pick < 15) return '0;
      else return {$urandom(), $urandom()};
   endfunction

   // Queue one request; every fourth block of 150 goes out back to back.
   task automatic add_request(logic [OP_W-1:0] op, logic [REQ_W-1:0] who,
                              logic [IDX_W-1:0] slot, logic [DIN_W-1:0] word);
      table_request item;
      item.operation = op;
      item.requester = who;
      item.index     = slot;
      item.data_in   = word;
      if ((queued_requests / 150) % 4 == 3 || $urandom_range(0, 99) < 55) item.gap = 0;
      else item.gap = idle_length();
      item.drain = (queued_requests % 230 == 229);
      request_queue.push_back(item);
      queued_requests++;
   endtask

   // ------------------------------------------------------------------
   // Request driver: advance at the falling edge, one request at a time.
   // ------------------------------------------------------------------
   table_request next_req;
   bit           staged    = 1'b0;
   int           idle_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         // pull the next request and start its idle stretch
         if (!staged && request_queue.size() > 0) begin
            next_req  = request_queue.pop_front();
            staged    = 1'b1;
            idle_left = next_req.gap;
         end
         if (staged && idle_left == 0 && (!next_req.drain || awaited_replies.size() == 0)) begin
            req_if.valid     <= 1'b1;
            req_if.operation <= next_req.operation;
            req_if.requester <= next_req.requester;
            req_if.index     <= next_req.index;
            req_if.data_in   <= next_req.data_in;
            staged = 1'b0;
         end else begin
            if (staged && idle_left > 0) idle_left--;
            // drop valid and scramble the payload while idle
            req_if.valid     <= 1'b0;
            req_if.operation <= OP_W'($urandom_range(0, 7));
            req_if.requester <= REQ_W'($urandom());
            req_if.index     <= IDX_W'($urandom());
            req_if.data_in   <= {$urandom(), $urandom()};
         end
      end
   end

   // ------------------------------------------------------------------
   // Reply backpressure: random stalls, with calm windows of steady ready.
   // ------------------------------------------------------------------
   int stall_left = 0;
   int edge_count = 0;

   always @(negedge clock) begin
      edge_count++;
      if (reset) begin
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if ((edge_count / 700) % 3 != 2 && $urandom_range(0, 99) < 25) begin
         stall_left = idle_length() - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predict on each accepted request, check each accepted reply.
   // ------------------------------------------------------------------
   task automatic flag_mismatch(string msg);
      $display("[%0t] reply %0d: %s", $time, replies_checked, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      table_reply want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            awaited_replies.push_back(apply_table_op(req_if.operation, req_if.requester,
                                                     req_if.index, req_if.data_in));
            requests_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_replies.size() == 0) begin
               flag_mismatch($sformatf("reply with no request outstanding, status %0d",
                                       rsp_if.status));
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_if.status !== want.status)
                  flag_mismatch($sformatf("status %0d, expected %0d",
                                          rsp_if.status, want.status));
               if (rsp_if.index_out !== want.index_out)
                  flag_mismatch($sformatf("index_out %0d, expected %0d",
                                          rsp_if.index_out, want.index_out));
               if (rsp_if.data_out !== want.data_out)
                  flag_mismatch($sformatf("data_out %h, expected %h",
                                          rsp_if.data_out, want.data_out));
               if (rsp_if.owner_out !== want.owner_out)
                  flag_mismatch($sformatf("owner_out %0d, expected %0d",
                                          rsp_if.owner_out, want.owner_out));
            end
            if (rsp_if.status <= ST_FULL) status_seen[rsp_if.status]++;
            replies_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence: reset, queue all stimulus, wait for the last reply.
   // ------------------------------------------------------------------
   initial begin
      int               pick;
      int               steps;
      logic [IDX_W-1:0] slot;
      logic [REQ_W-1:0] owner_id;

      // hold every input at a known value from time zero
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.operation = OP_READ;
      req_if.requester = '0;
      req_if.index     = '0;
      req_if.data_in   = '0;
      rsp_if.ready     = 1'b1;
      foreach (status_seen[k]) status_seen[k] = 0;
      foreach (row_state[k]) begin
         row_state[k] = REC_EMPTY;
         row_data[k]  = '0;
         row_owner[k] = '0;
      end
      live_records = START_RECORDS;

      // directed opening: empty, not-locked and bad-index errors on a blank table, then one record through
      // the lock rules, then the zero requester and a first append
      add_request(OP_READ,     16'd1,   10'd0,    '0);
      add_request(OP_DELETE,   16'd1,   10'd5,    '0);
      add_request(OP_UNDELETE, 16'd1,   10'd5,    '0);
      add_request(OP_LOCK,     16'd1,   10'd5,    '0);
      add_request(OP_UNLOCK,   16'd1,   10'd5,    '0);
      add_request(OP_WRITE,    '1,      10'd999,  '1);
      add_request(OP_READ,     16'd1,   10'd1000, '0);
      add_request(OP_READ,     16'd1,   '1,       '0);
      add_request(OP_UNDEFINED, '1,     10'd3,    '1);
      add_request(OP_WRITE,    16'd1,   10'd0,    '0);
      add_request(OP_READ,     16'd2,   10'd0,    '0);
      add_request(OP_LOCK,     16'd1,   10'd0,    '0);
      add_request(OP_LOCK,     16'd1,   10'd0,    '0);
      add_request(OP_READ,     16'd2,   10'd0,    '0);
      add_request(OP_WRITE,    16'd2,   10'd0,    '1);
      add_request(OP_UNLOCK,   16'd2,   10'd0,    '0);
      add_request(OP_DELETE,   16'd1,   10'd0,    '0);
      add_request(OP_READ,     16'd1,   10'd0,    '0);
      add_request(OP_UNDELETE, 16'd1,   10'd0,    '0);
      add_request(OP_UNDELETE, 16'd1,   10'd0,    '0);
      add_request(OP_DELETE,   16'd1,   10'd0,    '0);
      add_request(OP_UNLOCK,   16'd1,   10'd0,    '0);
      add_request(OP_WRITE,    16'd1,   10'd0,    64'h8000_0000_0000_0001);
      add_request(OP_UNLOCK,   16'd1,   10'd0,    '0);
      add_request(OP_LOCK,     '0,      10'd999,  '0);
      add_request(OP_APPEND,   16'd3,   '1,       64'hA5A5_5A5A_0F0F_F0F0);

      // random part: mostly lock sessions on one record, the rest loose requests;
      // appends are frequent enough to fill the table and keep hitting the full case
      pick = queued_requests + RANDOM_REQUESTS;
      while (queued_requests < pick) begin
         if ($urandom_range(0, 99) < 60) begin
            slot     = pick_slot();
            owner_id = pick_client();
            if ($urandom_range(0, 1)) add_request(OP_WRITE, owner_id, slot, pick_word());
            add_request(OP_LOCK, owner_id, slot, pick_word());
            steps = $urandom_range(1, 5);
            repeat (steps) begin
               // now and then another client barges in
               add_request(OP_W'($urandom_range(OP_WRITE, OP_UNDELETE)),
                           ($urandom_range(0, 99) < 20) ? pick_client() : owner_id,
                           slot, pick_word());
            end
            add_request(OP_UNLOCK, ($urandom_range(0, 99) < 85) ? owner_id : pick_client(),
                        slot, pick_word());
         end else begin
            steps = $urandom_range(0, 99);
            if (steps < 30)
               add_request(OP_APPEND, pick_client(), IDX_W'($urandom()), pick_word());
            else if (steps < 36)
               add_request(OP_UNDEFINED, pick_client(), pick_slot(), pick_word());
            else
               add_request(OP_W'($urandom_range(OP_WRITE, OP_UNLOCK)), pick_client(),
                           pick_slot(), pick_word());
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait out the clearing pass and all traffic, then let stray replies show
      while (request_queue.size() > 0 || staged || req_if.valid || awaited_replies.size() > 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("covered %0d requests, %0d replies checked, %0d records live at the end",
               requests_taken, replies_checked, live_records);
      $display("statuses: ok %0d bad %0d other-lock %0d empty %0d deleted %0d occupied %0d",
               status_seen[ST_OK], status_seen[ST_BAD_INDEX], status_seen[ST_LOCKED_OTHER],
               status_seen[ST_EMPTY], status_seen[ST_DELETED], status_seen[ST_OCCUPIED]);
      $display("          relock %0d not-locked %0d full %0d",
               status_seen[ST_ALREADY_LOCKED], status_seen[ST_NOT_LOCKED],
               status_seen[ST_FULL]);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, clearing pass included.
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
